[src/quaternion_rate_integrator_macros.svh]
// assertion macros for the quaternion rate integrator
// used by the top level; expects clk and rst_n in scope
`ifndef QUATERNION_RATE_INTEGRATOR_MACROS_SVH
`define QUATERNION_RATE_INTEGRATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define QRI_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qri check failed");
`define QRI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qri check failed");
`else
`define QRI_ASSERT_IMPLY(lbl, ante, cons)
`define QRI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/qri_pkg.sv]
// shared types, constants and helpers of the quaternion rate integrator
// no dependencies
package qri_pkg;

  localparam int QFRAC    = 30;
  localparam int DW       = 32;
  localparam int HSHIFT   = 49 - QFRAC;
  localparam int ACC_W    = 68;
  localparam int PROD_W   = 66;
  localparam int OPND_W   = 33;
  localparam int MAG_W    = 65;
  localparam int ROOT_W   = 33;
  localparam int CFG_IDX_W = 8;

  localparam logic [MAG_W-1:0] MAG_FLOOR = MAG_W'(11529);
  localparam logic signed [DW-1:0] QONE =
    (QFRAC >= DW - 1) ? {1'b0, {(DW-1){1'b1}}} : DW'(64'd1 << QFRAC);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_W   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_START_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_START_Y   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_START_Z   = CFG_IDX_W'(4);

  typedef enum logic [3:0] {
    S_IDLE, S_HGO, S_HWAIT, S_DGO, S_DWAIT, S_UPD, S_SGO, S_SWAIT,
    S_RGO, S_RWAIT, S_VGO, S_VWAIT, S_OUT
  } qri_state_t;

  // hamilton product terms: h index, q index, negate, per component and term
  localparam logic [1:0] D_HSEL [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd0},
    '{2'd1, 2'd2, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd1, 2'd0}};
  localparam logic [1:0] D_QSEL [4][4] = '{
    '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd0, 2'd3, 2'd2, 2'd0},
    '{2'd0, 2'd1, 2'd3, 2'd0}, '{2'd0, 2'd2, 2'd1, 2'd0}};
  localparam logic D_NEG [4][4] = '{
    '{1'b1, 1'b1, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b1, 1'b0}};

  // saturate a wide signed value to the component width
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
    if (v > hi) return {1'b0, {(DW-1){1'b1}}};
    if (v < lo) return {1'b1, {(DW-1){1'b0}}};
    return v[DW-1:0];
  endfunction

endpackage

[src/qri_mul.sv]
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on qri_pkg
module qri_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [qri_pkg::OPND_W-1:0]  opa,
  input  logic signed [qri_pkg::OPND_W-1:0]  opb,
  output logic                               done,
  output logic signed [qri_pkg::PROD_W-1:0]  prod
);
  import qri_pkg::*;

  localparam int CNT_W = $clog2(OPND_W);

  logic                 act_r, act_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [MAG_W-1:0]     mcand_r, mcand_nxt;
  logic [OPND_W-1:0]    mplier_r, mplier_nxt;
  logic [MAG_W-1:0]     acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;

  // load magnitudes, then shift and add
  always_comb begin
    act_nxt    = act_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    if (start) begin
      act_nxt    = 1'b1;
      cnt_nxt    = '0;
      mcand_nxt  = MAG_W'(opa[OPND_W-1] ? -opa : opa);
      mplier_nxt = opb[OPND_W-1] ? -opb : opb;
      acc_nxt    = '0;
      neg_nxt    = opa[OPND_W-1] ^ opb[OPND_W-1];
    end else if (act_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = {mcand_r[MAG_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[OPND_W-1:1]};
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(OPND_W - 1)) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    neg_r    <= neg_nxt;
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});

endmodule

[src/qri_sqrt.sv]
// digit-by-digit integer square root, two radicand bits per cycle
// depends on qri_pkg
module qri_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qri_pkg::MAG_W-1:0]   radicand,
  output logic                        done,
  output logic [qri_pkg::ROOT_W-1:0]  root
);
  import qri_pkg::*;

  localparam int SRC_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic                 act_r, act_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SRC_W-1:0]     src_r, src_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]    root_r, root_nxt;
  logic [REM_W+1:0]     rem_t;
  logic [REM_W+1:0]     trial;

  // one root bit per cycle
  always_comb begin
    act_nxt  = act_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    src_nxt  = src_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_t    = {rem_r, src_r[SRC_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      act_nxt  = 1'b1;
      cnt_nxt  = '0;
      src_nxt  = SRC_W'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (act_r) begin
      src_nxt = {src_r[SRC_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_nxt  = REM_W'(rem_t - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    src_r  <= src_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[src/qri_div.sv]
// restoring divider for mag * 2^QFRAC / root, one quotient bit per cycle
// depends on qri_pkg
module qri_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qri_pkg::DW-1:0]      numer,
  input  logic [qri_pkg::ROOT_W-1:0]  denom,
  output logic                        done,
  output logic                        ovf,
  output logic [qri_pkg::ROOT_W-1:0]  quo
);
  import qri_pkg::*;

  localparam int STEPS = DW + QFRAC;
  localparam int CNT_W = $clog2(STEPS);

  logic                 act_r, act_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [STEPS-1:0]     dvd_r, dvd_nxt;
  logic [ROOT_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0]    quo_r, quo_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [ROOT_W:0]      rem_t;
  logic                 ge;

  // shift one dividend bit in, compare, subtract
  always_comb begin
    act_nxt  = act_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    rem_t    = {rem_r, dvd_r[STEPS-1]};
    ge       = rem_t >= {1'b0, denom};
    if (start) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = {numer, {QFRAC{1'b0}}};
      rem_nxt = '0;
      quo_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (act_r) begin
      dvd_nxt = {dvd_r[STEPS-2:0], 1'b0};
      rem_nxt = ge ? ROOT_W'(rem_t - {1'b0, denom}) : rem_t[ROOT_W-1:0];
      quo_nxt = {quo_r[ROOT_W-2:0], ge};
      ovf_nxt = ovf_r | quo_r[ROOT_W-1];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quo  = quo_r;

endmodule

[src/quaternion_rate_integrator.sv]
// quaternion rate integrator top level: registers, sequencer, datapath
// depends on qri_pkg, qri_mul, qri_sqrt, qri_div and the macros header
//
// channel  dir  handshake                 payload
// in_      in   in_tvalid/in_tready       tdata rate_x,rate_y,rate_z; tuser restart
// out_     out  out_tvalid/out_tready     tdata quat_w..quat_z; tuser below_floor
// cfg_     in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// each item runs nineteen passes of the serial multiplier, then, unless the squared
// magnitude is at or below the floor, a root and four divisions
// one item is in work at a time; the result waits in an output register
// reset gives the identity orientation; cfg is always ready
`include "quaternion_rate_integrator_macros.svh"
module quaternion_rate_integrator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [95:0]                        in_tdata,   // rate_x, rate_y, rate_z
  input  logic                               in_tuser,   // restart
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [127:0]                       out_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic                               out_tuser,  // below_floor
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qri_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qri_pkg::DW-1:0]             cfg_data
);
  import qri_pkg::*;

  qri_state_t state_r, state_nxt;
  logic [1:0]               k_r, k_nxt;
  logic [1:0]               term_r, term_nxt;
  logic [DW-1:0]            ts_r;
  logic signed [DW-1:0]     start_r [4];
  logic signed [DW-1:0]     rate_r [3];
  logic signed [DW-1:0]     h_r [3], h_nxt [3];
  logic signed [DW-1:0]     q_r [4], q_nxt [4];
  logic signed [DW-1:0]     nq_r [4], nq_nxt [4];
  logic signed [ACC_W-1:0]  dacc_r, dacc_nxt;
  logic [MAG_W-1:0]         m2_r, m2_nxt;
  logic                     low_r, low_nxt;
  logic signed [DW-1:0]     outq_r [4];
  logic                     outlow_r;
  logic                     out_full_r, out_full_nxt;

  logic                     in_acc, out_load, is_low;
  logic                     mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [ROOT_W-1:0]        root, div_quo;
  logic                     div_ovf;
  logic signed [DW-1:0]     hsel_v, qsel_v, qk_v, ratek_v;
  logic [DW-1:0]            div_num;
  logic signed [ACC_W-1:0]  prod_x, dsum;
  logic                     big;
  logic signed [DW-1:0]     scaled;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign is_low    = m2_r <= MAG_FLOOR;
  assign out_load  = (state_r == S_OUT) && !out_full_r;

  // operand selection
  always_comb begin
    case (k_r)
      2'd0:    begin ratek_v = rate_r[0]; qk_v = q_r[0]; end
      2'd1:    begin ratek_v = rate_r[1]; qk_v = q_r[1]; end
      2'd2:    begin ratek_v = rate_r[2]; qk_v = q_r[2]; end
      default: begin ratek_v = rate_r[2]; qk_v = q_r[3]; end
    endcase
    case (D_HSEL[k_r][term_r])
      2'd0:    hsel_v = h_r[0];
      2'd1:    hsel_v = h_r[1];
      default: hsel_v = h_r[2];
    endcase
    case (D_QSEL[k_r][term_r])
      2'd0:    qsel_v = q_r[0];
      2'd1:    qsel_v = q_r[1];
      2'd2:    qsel_v = q_r[2];
      default: qsel_v = q_r[3];
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_HGO;
      S_HGO:   state_nxt = S_HWAIT;
      S_HWAIT: if (mul_done) state_nxt = (k_r == 2'd2) ? S_DGO : S_HGO;
      S_DGO:   state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (mul_done) state_nxt = (k_r == 2'd3 && term_r == 2'd2) ? S_UPD : S_DGO;
      end
      S_UPD:   state_nxt = S_SGO;
      S_SGO:   state_nxt = S_SWAIT;
      S_SWAIT: if (mul_done) state_nxt = (k_r == 2'd3) ? S_RGO : S_SGO;
      S_RGO:   state_nxt = is_low ? S_OUT : S_RWAIT;
      S_RWAIT: if (sqrt_done) state_nxt = S_VGO;
      S_VGO:   state_nxt = S_VWAIT;
      S_VWAIT: if (div_done) state_nxt = (k_r == 2'd3) ? S_OUT : S_VGO;
      S_OUT:   if (!out_full_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    in_tready  = state_r == S_IDLE;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      S_HGO: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(ratek_v);
        mul_b     = $signed({1'b0, ts_r});
      end
      S_DGO: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(hsel_v);
        mul_b     = OPND_W'(qsel_v);
      end
      S_SGO: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(qk_v);
        mul_b     = OPND_W'(qk_v);
      end
      S_RGO:   sqrt_start = !is_low;
      S_VGO:   div_start  = 1'b1;
      default: mul_start  = 1'b0;
    endcase
  end

  // product accumulation and result scaling
  always_comb begin
    prod_x  = ACC_W'(mul_p);
    dsum    = dacc_r + (D_NEG[k_r][term_r] ? -prod_x : prod_x);
    div_num = qk_v[DW-1] ? DW'(-qk_v) : DW'(qk_v);
    big     = div_ovf || div_quo[ROOT_W-1];
    if (qk_v[DW-1]) begin
      if (big || (div_quo[DW-1] && |div_quo[DW-2:0])) scaled = {1'b1, {(DW-1){1'b0}}};
      else scaled = -$signed(div_quo[DW-1:0]);
    end else begin
      if (big || div_quo[DW-1]) scaled = {1'b0, {(DW-1){1'b1}}};
      else scaled = $signed(div_quo[DW-1:0]);
    end
  end

  // datapath register updates
  always_comb begin
    k_nxt        = k_r;
    term_nxt     = term_r;
    h_nxt        = h_r;
    q_nxt        = q_r;
    nq_nxt       = nq_r;
    dacc_nxt     = dacc_r;
    m2_nxt       = m2_r;
    low_nxt      = low_r;
    out_full_nxt = out_full_r;
    if (out_tvalid && out_tready) out_full_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        if (in_acc && in_tuser) q_nxt = start_r;
      end
      S_HWAIT: begin
        if (mul_done) begin
          h_nxt[k_r] = sat_dw(prod_x >>> HSHIFT);
          k_nxt      = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          term_nxt   = '0;
          dacc_nxt   = '0;
        end
      end
      S_DWAIT: begin
        if (mul_done) begin
          if (term_r == 2'd2) begin
            nq_nxt[k_r] = sat_dw(ACC_W'(qk_v) + (dsum >>> QFRAC));
            term_nxt    = '0;
            dacc_nxt    = '0;
            k_nxt       = k_r + 2'd1;
          end else begin
            term_nxt = term_r + 2'd1;
            dacc_nxt = dsum;
          end
        end
      end
      S_UPD: begin
        q_nxt  = nq_r;
        m2_nxt = '0;
        k_nxt  = '0;
      end
      S_SWAIT: begin
        if (mul_done) begin
          m2_nxt = m2_r + mul_p[MAG_W-1:0];
          k_nxt  = k_r + 2'd1;
        end
      end
      S_RGO: begin
        low_nxt = is_low;
        k_nxt   = '0;
      end
      S_VWAIT: begin
        if (div_done) begin
          q_nxt[k_r] = scaled;
          k_nxt      = k_r + 2'd1;
        end
      end
      S_OUT:   if (!out_full_r) out_full_nxt = 1'b1;
      default: k_nxt = k_r;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      k_r        <= '0;
      term_r     <= '0;
      out_full_r <= 1'b0;
      q_r        <= '{QONE, '0, '0, '0};
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      term_r     <= term_nxt;
      out_full_r <= out_full_nxt;
      q_r        <= q_nxt;
    end
    h_r    <= h_nxt;
    nq_r   <= nq_nxt;
    dacc_r <= dacc_nxt;
    m2_r   <= m2_nxt;
    low_r  <= low_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= '0;
      start_r <= '{32'sh4000_0000, '0, '0, '0};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIME_STEP: ts_r       <= cfg_data;
        REG_START_W:   start_r[0] <= cfg_data;
        REG_START_X:   start_r[1] <= cfg_data;
        REG_START_Y:   start_r[2] <= cfg_data;
        REG_START_Z:   start_r[3] <= cfg_data;
        default:       ts_r       <= ts_r;
      endcase
    end
  end

  // input capture and output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate_r[0] <= in_tdata[31:0];
      rate_r[1] <= in_tdata[63:32];
      rate_r[2] <= in_tdata[95:64];
    end
    if (out_load) begin
      outq_r   <= q_r;
      outlow_r <= low_r;
    end
  end

  assign out_tvalid = out_full_r;
  assign out_tdata  = {outq_r[3], outq_r[2], outq_r[1], outq_r[0]};
  assign out_tuser  = outlow_r;

  qri_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .opa   (mul_a),
    .opb   (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  qri_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (m2_r),
    .done     (sqrt_done),
    .root     (root)
  );

  qri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_num),
    .denom (root),
    .done  (div_done),
    .ovf   (div_ovf),
    .quo   (div_quo)
  );

  // checks
  `QRI_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `QRI_ASSERT_NEXT(a_hold_when_full, (state_r == S_OUT) && out_full_r && !out_tready, state_r == S_OUT)
  `QRI_ASSERT_IMPLY(a_mul_done_waited, mul_done, (state_r == S_HWAIT) || (state_r == S_DWAIT) || (state_r == S_SWAIT))

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// testbench for the quaternion rate integrator: random and directed rate samples
// depends on qri_pkg and quaternion_rate_integrator; self-checking predictor below

typedef struct {
  logic signed [31:0] comp [4];   // w, x, y, z
  logic               low;
} quat_result_t;

class orientation_scoreboard;
  logic        [31:0] step_len;
  logic signed [31:0] start_q [4];
  logic signed [31:0] orient [4];
  quat_result_t       pending_q [$];
  int                 mismatches;

  function new();
    step_len   = '0;
    start_q    = '{qri_pkg::QONE, 32'sd0, 32'sd0, 32'sd0};
    orient     = '{qri_pkg::QONE, 32'sd0, 32'sd0, 32'sd0};
    mismatches = 0;
  endfunction

  function void write_reg(logic [7:0] idx, logic [31:0] val);
    case (idx)
      qri_pkg::REG_TIME_STEP: step_len   = val;
      qri_pkg::REG_START_W:   start_q[0] = val;
      qri_pkg::REG_START_X:   start_q[1] = val;
      qri_pkg::REG_START_Y:   start_q[2] = val;
      qri_pkg::REG_START_Z:   start_q[3] = val;
      default: ;
    endcase
  endfunction

  function logic signed [31:0] clip(logic signed [67:0] v);
    if (v > 68'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -68'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function logic signed [67:0] mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [67:0] wa, wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // integrate one rate sample and queue the new orientation
  function void note(logic signed [31:0] rate [3], logic restart);
    logic signed [67:0] p, d [4], ts;
    logic signed [31:0] h [3], q [4];
    logic        [67:0] m2, root, t, mag;
    logic        [99:0] quo;
    quat_result_t       res;
    if (restart) orient = start_q;
    ts = {36'd0, step_len};
    for (int i = 0; i < 3; i++) begin
      p = rate[i];
      p = p * ts;
      h[i] = clip(p >>> qri_pkg::HSHIFT);
    end
    q = orient;
    // hamilton product (0,h)*q, floored to the component format
    d[0] = (-mul(h[0], q[1]) - mul(h[1], q[2]) - mul(h[2], q[3])) >>> 30;
    d[1] = (mul(h[0], q[0]) + mul(h[1], q[3]) - mul(h[2], q[2])) >>> 30;
    d[2] = (mul(h[1], q[0]) + mul(h[2], q[1]) - mul(h[0], q[3])) >>> 30;
    d[3] = (mul(h[2], q[0]) + mul(h[0], q[2]) - mul(h[1], q[1])) >>> 30;
    m2 = '0;
    for (int i = 0; i < 4; i++) begin
      p = q[i];
      q[i] = clip(p + d[i]);
      m2 = m2 + mul(q[i], q[i]);
    end
    res.low = (m2 <= 68'd11529);
    if (!res.low) begin
      root = '0;
      for (int b = 32; b >= 0; b--) begin
        t = root | (68'd1 << b);
        if (t * t <= m2) root = t;
      end
      for (int i = 0; i < 4; i++) begin
        p = q[i];
        mag = (p < 0) ? -p : p;
        quo = ({32'd0, mag} << 30) / {32'd0, root};
        if (p < 0) q[i] = (quo > 100'h80000000) ? 32'sh80000000 : -quo[31:0];
        else q[i] = (quo > 100'h7FFFFFFF) ? 32'sh7FFFFFFF : quo[31:0];
      end
    end
    res.comp = q;
    orient = q;
    pending_q.push_back(res);
  endfunction

  function void check(logic [127:0] data, logic low);
    quat_result_t want;
    bit bad;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result transaction %h", data);
      return;
    end
    want = pending_q.pop_front();
    bad = (low !== want.low);
    for (int i = 0; i < 4; i++) bad |= (data[32*i +: 32] !== want.comp[i]);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h %h %h %h low %b, got %h %h %h %h low %b",
                 want.comp[0], want.comp[1], want.comp[2], want.comp[3], want.low,
                 data[31:0], data[63:32], data[95:64], data[127:96], low);
    end
  endfunction
endclass

module testbench;
  import qri_pkg::*;

  localparam logic [7:0] REG_UNUSED = 8'd9;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;   // rate_x, rate_y, rate_z
  logic         in_tuser = 1'b0; // restart
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // quat_w, quat_x, quat_y, quat_z
  logic         out_tuser;       // below_floor
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  int send_idle = 0;
  int recv_stall = 0;
  orientation_scoreboard sb = new();

  quaternion_rate_integrator dut (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  // result monitor
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tuser);

  // register write once every transaction in flight has come out
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    in_tvalid <= 1'b0;
    wait (sb.pending_q.size() == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz, logic rs);
    logic signed [31:0] r [3];
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rz, ry, rx};
    in_tuser  <= rs;
    do @(posedge clk); while (!in_tready);
    r = '{rx, ry, rz};
    sb.note(r, rs);
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (sb.pending_q.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic load_start(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    write_reg(REG_START_W, w);
    write_reg(REG_START_X, x);
    write_reg(REG_START_Y, y);
    write_reg(REG_START_Z, z);
  endtask

  function automatic logic [31:0] pick_rate();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(2 * 2 ** 21) - 2 ** 21;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++)
      send(pick_rate(), pick_rate(), pick_rate(), $urandom_range(11) == 0);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero step renormalizes, then extreme rates and steps
    send(32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0);
    write_reg(REG_TIME_STEP, 32'd42949673);
    send(32'h0, 32'h0, 32'h0, 1'b0);
    send(32'h00010000, 32'h0, 32'h0, 1'b0);
    send(32'h0, 32'hFFFF0000, 32'h00010000, 1'b0);
    send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    send(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
    drain();
    write_reg(REG_TIME_STEP, 32'hFFFFFFFF);
    send(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
    send(32'hFFFFFFFF, 32'h00000001, 32'h12345678, 1'b0);
    // full-scale magnitude and tiny magnitude starts
    drain();
    load_start(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    write_reg(REG_TIME_STEP, 32'h0);
    send(32'h0, 32'h0, 32'h0, 1'b1);
    write_reg(REG_UNUSED, 32'hDEADBEEF);
    load_start(32'h0, 32'h0, 32'h0, 32'h0);
    send(32'h0, 32'h0, 32'h0, 1'b1);
    load_start(32'h00000040, 32'hFFFFFFC0, 32'h0, 32'h00000010);
    send(32'h0, 32'h0, 32'h0, 1'b1);
    write_reg(REG_TIME_STEP, 32'hFFFFFFFF);
    send(32'h7FFFFFFF, 32'h0, 32'h80000000, 1'b1);
    load_start(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send(32'h00010000, 32'h00020000, 32'hFFFD0000, 1'b1);
    send(32'h0, 32'h0, 32'h0, 1'b0);
    drain();

    // random phases with different idling and settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 75; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 75; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      write_reg(REG_TIME_STEP, (ph == 3) ? 32'h00000001 : $urandom_range(32'h04000000));
      load_start($urandom, $urandom, $urandom, $urandom);
      send(pick_rate(), pick_rate(), pick_rate(), 1'b1);
      load_start(QONE, 32'h0, 32'h0, 32'h0);
      random_run(100);
      drain();
      write_reg(REG_TIME_STEP, (ph == 1) ? 32'hFFFFFFFF : $urandom);
      random_run(100);
      drain();
    end

    repeat (1200) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("testbench: errors");
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/qri_pkg.sv
src/qri_mul.sv
src/qri_sqrt.sv
src/qri_div.sv
src/quaternion_rate_integrator.sv
tb/sv/testbench.sv
